>>> hw/rtl/ultrasonic_echo_ranger_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the echo ranger RTL
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_ECHO_RANGER_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_DEFINES_SVH

// Clocked check, disabled while reset is high.
`define UER_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Same-cycle implication.
`define UER_ASSERT_IMPL(lbl, ante, cons, msg) \
   `UER_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define UER_ASSERT_NEXT(lbl, ante, cons, msg) \
   `UER_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

>>> hw/rtl/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg
// Types and constants of the ultrasonic echo ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

   localparam int unsigned SENSOR_COUNT_DEF = 4;
   localparam int unsigned LEVELS_W         = 4;
   localparam int unsigned TRIG_W           = 16;
   localparam int unsigned COUNT_W          = 24;
   localparam int unsigned CSR_IDX_W        = 1;
   localparam int unsigned CSR_DATA_W       = 24;

   localparam logic [TRIG_W-1:0]  TRIGGER_TICKS_RST = 16'd1000;
   localparam logic [COUNT_W-1:0] TIMEOUT_TICKS_RST = 24'd1000000;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER_TICKS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_TICKS = 1'd1;

   // report status codes
   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_START_TMO   = 2'd1;
   localparam logic [1:0] STATUS_END_TMO     = 2'd2;

   typedef enum logic [3:0] {
      PH_IDLE   = 4'b0001,
      PH_TRIG   = 4'b0010,
      PH_WSTART = 4'b0100,
      PH_WEND   = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [TRIG_W-1:0]  trigger_ticks;
      logic [COUNT_W-1:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic [LEVELS_W-1:0] trigger_levels;
      logic                report_valid;
      logic [1:0]          sensor_index;
      logic [1:0]          status;
      logic [COUNT_W-1:0]  pulse_width;
      logic                round_last;
      logic                busy_res;
   } result_type;

endpackage

>>> hw/rtl/uer_if.sv
// ----------------------------------------------------------------------------
// uer_req_if / uer_rsp_if
// Valid/ready channels of the echo ranger.
// ----------------------------------------------------------------------------
interface uer_req_if;
   import uer_pkg::*;

   logic                valid;
   logic                ready;
   logic                start_req;
   logic [LEVELS_W-1:0] echo_levels;

   modport source (output valid, start_req, echo_levels, input ready);
   modport sink   (input valid, start_req, echo_levels, output ready);
endinterface

interface uer_rsp_if;
   import uer_pkg::*;

   logic                valid;
   logic                ready;
   logic [LEVELS_W-1:0] trigger_levels;
   logic                report_valid;
   logic [1:0]          sensor_index;
   logic [1:0]          status;
   logic [COUNT_W-1:0]  pulse_width;
   logic                round_last;
   logic                busy_res;

   modport source (output valid, trigger_levels, report_valid, sensor_index, status,
                   pulse_width, round_last, busy_res, input ready);
   modport sink   (input valid, trigger_levels, report_valid, sensor_index, status,
                   pulse_width, round_last, busy_res, output ready);
endinterface

>>> hw/rtl/uer_core.sv
// ----------------------------------------------------------------------------
// uer_core
// Per-tick sequencer: trigger, wait for echo rise, time echo high.
// ----------------------------------------------------------------------------
`include "ultrasonic_echo_ranger_defines.svh"

module uer_core #(
   parameter int unsigned SensorCount = uer_pkg::SENSOR_COUNT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  logic                                start_req,
   input  logic [uer_pkg::LEVELS_W-1:0]        echo_levels,
   input  uer_pkg::cfg_type                    cfg,
   output uer_pkg::result_type                 result
);
   import uer_pkg::*;

   localparam int unsigned SelW = (SensorCount > 1) ? $clog2(SensorCount) : 1;
   localparam logic [SelW-1:0] LastSensor = SelW'(SensorCount - 1);

   phase_type          phase_ff, phase_in;
   logic [SelW-1:0]    sensor_ff, sensor_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic [3:0]         sens_wide;
   logic               sens_exists;
   logic               echo;
   logic [COUNT_W-1:0] count_inc;
   logic               report;
   logic [1:0]         status;
   logic [COUNT_W-1:0] width;

   assign sens_wide   = 4'(sensor_ff);
   assign sens_exists = sens_wide < 4'd4;
   assign echo        = sens_exists && echo_levels[sens_wide[1:0]];
   assign count_inc   = count_ff + COUNT_W'(1);

   always_comb begin
      phase_in  = phase_ff;
      sensor_in = sensor_ff;
      count_in  = count_ff;
      report    = 1'b0;
      status    = STATUS_OK;
      width     = '0;
      result    = '0;
      result.busy_res = (phase_ff != PH_IDLE);

      case (phase_ff)
         PH_IDLE: begin
            if (start_req) begin
               phase_in  = PH_TRIG;
               sensor_in = '0;
               count_in  = '0;
            end
         end
         PH_TRIG: begin
            if (sens_exists) begin
               result.trigger_levels = 4'b0001 << sens_wide[1:0];
            end
            count_in = count_inc;
            if (count_inc >= COUNT_W'(cfg.trigger_ticks)) begin
               phase_in = PH_WSTART;
               count_in = '0;
            end
         end
         PH_WSTART: begin
            if (echo) begin
               phase_in = PH_WEND;
               count_in = COUNT_W'(1);
            end else begin
               count_in = count_inc;
               if (count_inc >= cfg.timeout_ticks) begin
                  report = 1'b1;
                  status = STATUS_START_TMO;
               end
            end
         end
         PH_WEND: begin
            if (!echo) begin
               report = 1'b1;
               status = STATUS_OK;
               width  = count_ff;
            end else begin
               count_in = count_inc;
               if (count_inc >= cfg.timeout_ticks) begin
                  report = 1'b1;
                  status = STATUS_END_TMO;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      if (report) begin
         result.report_valid = 1'b1;
         result.sensor_index = sens_wide[1:0];
         result.status       = status;
         result.pulse_width  = width;
         count_in            = '0;
         if (sensor_ff == LastSensor) begin
            result.round_last = 1'b1;
            phase_in          = PH_IDLE;
            sensor_in         = '0;
         end else begin
            phase_in  = PH_TRIG;
            sensor_in = sensor_ff + SelW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         sensor_ff <= '0;
         count_ff  <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         sensor_ff <= sensor_in;
         count_ff  <= count_in;
      end
   end

   `UER_ASSERT_NEXT(a_round_ends_idle, step && result.report_valid && result.round_last,
      phase_ff == PH_IDLE && sensor_ff == '0, "round did not return to idle")
   `UER_ASSERT_NEXT(a_start_enters_trig, step && phase_ff == PH_IDLE && start_req,
      phase_ff == PH_TRIG && sensor_ff == '0 && count_ff == '0, "start did not arm sensor 0")
   `UER_ASSERT_IMPL(a_trig_only_in_trig, result.trigger_levels != '0,
      phase_ff == PH_TRIG, "trigger driven outside trigger phase")
   `UER_ASSERT_NEXT(a_report_clears_count, step && result.report_valid,
      count_ff == '0, "tick count not cleared after report")

endmodule

>>> hw/rtl/ultrasonic_echo_ranger.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// Sequential echo pulse timer for a bank of ultrasonic range sensors.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ch carries one timer tick per item: start_req and the echo pin levels
//    (bit i = sensor i). Every accepted item yields exactly one item on rsp_ch.
//  - rsp_ch gives the trigger pin drive for that tick, plus a report (sensor,
//    status, pulse width, last-of-round flag) when a sensor finishes.
//  - csr_we/csr_index/csr_wdata write trigger_ticks (index 0) and
//    timeout_ticks (index 1); write only while no item is in flight.
// Timing:
//  - Throughput 1 item per cycle while req_ch.ready is high. The sequencer
//    and tick counter sit between the state registers and the result
//    register (or skid): one 24-bit increment and compare per tick.
//  - A two-entry output buffer (result reg + skid) lets req_ch.ready stay
//    high for one more item while a result waits; ready drops only when both
//    entries hold results the receiver has not taken.
// Reset: synchronous, active high. Phase goes idle, sensor 0, count 0,
//  registers to 1000 / 1000000, output buffer empty.
// ----------------------------------------------------------------------------
`include "ultrasonic_echo_ranger_defines.svh"

module ultrasonic_echo_ranger #(
   parameter int unsigned SensorCount = uer_pkg::SENSOR_COUNT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   uer_req_if.sink                        req_ch,
   uer_rsp_if.source                      rsp_ch,
   input  logic                           csr_we,
   input  logic [uer_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [uer_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import uer_pkg::*;

   // configuration registers
   logic [TRIG_W-1:0]  trigger_ticks_ff;
   logic [COUNT_W-1:0] timeout_ticks_ff;
   cfg_type            cfg;

   always_ff @(posedge clock) begin
      if (reset) begin
         trigger_ticks_ff <= TRIGGER_TICKS_RST;
         timeout_ticks_ff <= TIMEOUT_TICKS_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TRIGGER_TICKS: trigger_ticks_ff <= csr_wdata[TRIG_W-1:0];
            CSR_TIMEOUT_TICKS: timeout_ticks_ff <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.trigger_ticks = trigger_ticks_ff;
   assign cfg.timeout_ticks = timeout_ticks_ff;

   // handshake
   logic push;
   logic pop;
   logic skid_valid_ff, skid_valid_in;
   logic out_valid_ff,  out_valid_in;
   result_type skid_data_ff, skid_data_in;
   result_type out_data_ff,  out_data_in;
   result_type tick_result;

   assign req_ch.ready = !skid_valid_ff;
   assign push         = req_ch.valid && req_ch.ready;
   assign pop          = out_valid_ff && rsp_ch.ready;

   // sequencer: state advances once per accepted tick
   uer_core #(
      .SensorCount (SensorCount)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (push),
      .start_req   (req_ch.start_req),
      .echo_levels (req_ch.echo_levels),
      .cfg         (cfg),
      .result      (tick_result)
   );

   // two-entry output buffer; skid only fills when the head is stalled
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = tick_result;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = tick_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.trigger_levels = out_data_ff.trigger_levels;
   assign rsp_ch.report_valid   = out_data_ff.report_valid;
   assign rsp_ch.sensor_index   = out_data_ff.sensor_index;
   assign rsp_ch.status         = out_data_ff.status;
   assign rsp_ch.pulse_width    = out_data_ff.pulse_width;
   assign rsp_ch.round_last     = out_data_ff.round_last;
   assign rsp_ch.busy_res       = out_data_ff.busy_res;

   `UER_ASSERT_IMPL(a_skid_behind_head, skid_valid_ff, out_valid_ff,
      "skid entry held with empty head")
   `UER_ASSERT_NEXT(a_skid_holds, skid_valid_ff && !rsp_ch.ready,
      skid_valid_ff && $stable(skid_data_ff), "skid entry lost while stalled")
   `UER_ASSERT_NEXT(a_accept_shows, push && !out_valid_ff,
      out_valid_ff && out_data_ff == $past(tick_result), "accepted item not registered")

endmodule
